FILE: src/lfp_pkg.sv
// ============================================================================
// lfp_pkg: shared types and constants of the lidar frame parser
// Status codes, frame layout constants and the result record.
// ============================================================================
package lfp_pkg;

    // Frame layout: two header bytes, six payload bytes, one checksum byte
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned PAYLOAD_LEN = 6;
    localparam int unsigned PIDX_W      = $clog2(PAYLOAD_LEN);

    localparam logic [7:0]       HDR_BYTE = 8'h59;
    localparam logic [CNT_W-1:0] HDR_LEN  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CSUM_POS = CNT_W'(8);

    // Field conversion constants
    localparam logic [15:0] DIST_MAX    = 16'hFFFF;
    localparam logic [19:0] SCALE_X10   = 20'd10;
    localparam logic [15:0] TEMP_OFFSET = 16'd2560;

    typedef enum logic [1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_OK       = 2'd1,
        STATUS_CSUM_ERR = 2'd2
    } status_t;

    typedef logic [PAYLOAD_LEN-1:0][7:0] payload_t;

    typedef struct packed {
        status_t            status;
        logic [15:0]        dist_cm;
        logic [15:0]        dist_mm;
        logic [15:0]        strength;
        logic signed [15:0] temp_tenths;
        logic               valid_res;
    } result_t;

endpackage

FILE: src/lidar_frame_parser.sv
// ============================================================================
// lidar_frame_parser: serial range-sensor frame parser
// Hunts for the two-byte header, collects six payload bytes, checks the
// checksum and returns one result per received byte.
// ============================================================================
//
//  channel   dir   tdata                               tuser
//  s_axis    in    [7:0] rx_byte                       -
//  m_axis    out   [15:0] dist_cm, [31:16] dist_mm,    [1:0] status
//                  [47:32] strength, [63:48] temp,
//                  [64] valid_res, [71:65] zero
//
//  One byte per cycle is accepted, sustained, while results are taken; each
//  request gives one result (input register, then result register).
//  The parse step (running sum, byte count, payload capture, a 16x4
//  multiply for each scaled field) sits between those two registers.
//  s_axis_tready follows m_axis_tready combinationally through the two
//  stages, so a full pipe stalls only when the result is not taken.
//  Reset clears the valid bits, the byte count and the running sum; the
//  payload bytes are always written before they are read.
//
module lidar_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // dist_cm, dist_mm, strength, temp_tenths,
                                        // valid_res, zero pad
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // input stage
    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;

    // parser state
    logic [lfp_pkg::CNT_W-1:0]  byte_count_reg;
    logic [lfp_pkg::CNT_W-1:0]  byte_count_next;
    logic [7:0]                 running_sum_reg;
    logic [7:0]                 running_sum_next;
    lfp_pkg::payload_t          payload_reg;

    // result stage
    logic                       out_valid_reg;
    lfp_pkg::result_t           out_reg;
    lfp_pkg::result_t           result;

    logic                       out_free;
    logic                       take;
    logic                       frame_end;
    logic                       pay_wr;
    logic [lfp_pkg::CNT_W-1:0]  pay_off;
    logic [lfp_pkg::PIDX_W-1:0] pay_idx;

    // Advance the result stage when it is empty or being drained
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign take          = in_valid_reg && out_free;

    // A count at or past the checksum position is treated as the checksum byte
    assign frame_end = (byte_count_reg >= lfp_pkg::CSUM_POS);
    assign pay_wr    = take && (byte_count_reg >= lfp_pkg::HDR_LEN) && !frame_end;
    assign pay_off   = byte_count_reg - lfp_pkg::HDR_LEN;
    assign pay_idx   = pay_off[lfp_pkg::PIDX_W-1:0];

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        if (take)
        begin
            if (byte_count_reg < lfp_pkg::HDR_LEN)
            begin
                // Hunt: a non-header byte drops back to the start, not rechecked
                if (in_byte_reg == lfp_pkg::HDR_BYTE)
                begin
                    byte_count_next  = byte_count_reg + 1'b1;
                    running_sum_next = running_sum_reg + in_byte_reg;
                end
                else
                begin
                    byte_count_next  = '0;
                    running_sum_next = '0;
                end
            end
            else if (!frame_end)
            begin
                byte_count_next  = byte_count_reg + 1'b1;
                running_sum_next = running_sum_reg + in_byte_reg;
            end
            else
            begin
                // Restart after the checksum byte, good or bad
                byte_count_next  = '0;
                running_sum_next = '0;
            end
        end
    end

    lfp_decode u_decode
    (
        .frame_end (frame_end),
        .rx_byte   (in_byte_reg),
        .sum       (running_sum_reg),
        .payload   (payload_reg),
        .result    (result)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= take;
            end
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
        end
    end

    // Payload registers: capture the input byte and payload bytes, hold the result
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (pay_wr)
        begin
            payload_reg[pay_idx] <= in_byte_reg;
        end
        if (take)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {7'b0, out_reg.valid_res, out_reg.temp_tenths,
                            out_reg.strength, out_reg.dist_mm, out_reg.dist_cm};

`ifndef SYNTHESIS
    // The byte count never runs past the checksum position
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= lfp_pkg::CSUM_POS)
        else $error("byte count beyond checksum position");

    // A checksum byte restarts the parser and yields a frame status
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && frame_end) |=>
            (byte_count_reg == '0) && (m_axis_tuser != lfp_pkg::STATUS_NONE))
        else $error("frame end did not restart or report");

    // Only a decoded frame carries nonzero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != lfp_pkg::STATUS_OK) |-> (m_axis_tdata == '0))
        else $error("fields set without a decoded frame");

    // A result is in flight only if an input was taken for it
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(m_axis_tvalid)) |-> $past(in_valid_reg))
        else $error("result without a request");
`endif

endmodule

FILE: src/lfp_decode.sv
// ============================================================================
// lfp_decode: checksum check and field conversion
// Turns the six stored payload bytes into the result record at frame end.
// ============================================================================
module lfp_decode
(
    input  logic                 frame_end,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           sum,
    input  lfp_pkg::payload_t    payload,
    output lfp_pkg::result_t     result
);

    logic [15:0] dcm;
    logic [15:0] str;
    logic [15:0] raw;
    logic [19:0] dist_x10;
    logic [19:0] temp_x10;
    logic [15:0] temp_scaled;
    logic [15:0] dmm;

    assign dcm = {payload[1], payload[0]};
    assign str = {payload[3], payload[2]};
    assign raw = {payload[5], payload[4]};

    assign dist_x10    = {4'b0, dcm} * lfp_pkg::SCALE_X10;
    assign temp_x10    = {4'b0, raw} * lfp_pkg::SCALE_X10;
    assign temp_scaled = temp_x10[18:3];

    // saturate anything past 16 bits; full-scale distance stays full-scale
    assign dmm = (dcm == lfp_pkg::DIST_MAX || dist_x10[19:16] != 4'b0)
               ? lfp_pkg::DIST_MAX : dist_x10[15:0];

    always_comb
    begin
        result = '0;
        if (frame_end)
        begin
            if (sum != rx_byte)
            begin
                result.status = lfp_pkg::STATUS_CSUM_ERR;
            end
            else
            begin
                result.status      = lfp_pkg::STATUS_OK;
                result.dist_cm     = dcm;
                result.dist_mm     = dmm;
                result.strength    = str;
                result.temp_tenths = temp_scaled - lfp_pkg::TEMP_OFFSET;
                result.valid_res   = (dcm != 16'd0) && (dcm != lfp_pkg::DIST_MAX);
            end
        end
    end

endmodule
